@@ rtl/lttc_pkg.sv @@
package lttc_pkg;

    localparam int MAX_BEAMS_DEF   = 2048;
    localparam int COS_ENTRIES_DEF = 256;

    // field and datapath widths
    localparam int RANGE_W = 16;
    localparam int SPEED_W = 16;
    localparam int TTC_W   = 16;
    localparam int ANGLE_W = 16;
    localparam int STEP_W  = 12;
    localparam int COS_W   = 15;
    localparam int DEN_W   = 30;
    localparam int NUM_W   = 41;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [RANGE_W-1:0] NO_RETURN = 16'hFFFF;
    localparam logic [TTC_W-1:0]   TTC_MAX   = 16'hFFFF;
    localparam logic [9:0]         MS_PER_S  = 10'd1000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd2;

    localparam logic [TTC_W-1:0]   THRESHOLD_RST = 16'd1500;
    localparam logic [ANGLE_W-1:0] START_RST     = 16'hA000;
    localparam logic [STEP_W-1:0]  STEP_RST      = 12'd24;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    // reciprocals of the series divisors (2n-1)(2n) in 0.64 fixed point, rounded up
    localparam logic [63:0] RCP_2   = 64'hFFFF_FFFF_FFFF_FFFF / 64'd2 + 64'd1;
    localparam logic [63:0] RCP_12  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd12 + 64'd1;
    localparam logic [63:0] RCP_30  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd30 + 64'd1;
    localparam logic [63:0] RCP_56  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd56 + 64'd1;
    localparam logic [63:0] RCP_90  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd90 + 64'd1;
    localparam logic [63:0] RCP_132 = 64'hFFFF_FFFF_FFFF_FFFF / 64'd132 + 64'd1;
    localparam logic [63:0] RCP_182 = 64'hFFFF_FFFF_FFFF_FFFF / 64'd182 + 64'd1;
    localparam logic [63:0] RCP_240 = 64'hFFFF_FFFF_FFFF_FFFF / 64'd240 + 64'd1;
    localparam logic [63:0] RCP_306 = 64'hFFFF_FFFF_FFFF_FFFF / 64'd306 + 64'd1;
    localparam logic [63:0] RCP_380 = 64'hFFFF_FFFF_FFFF_FFFF / 64'd380 + 64'd1;
    localparam logic [63:0] RCP_462 = 64'hFFFF_FFFF_FFFF_FFFF / 64'd462 + 64'd1;
    localparam logic [63:0] RCP_552 = 64'hFFFF_FFFF_FFFF_FFFF / 64'd552 + 64'd1;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [63:0] series_rcp(input int n);
        logic [63:0] r;
        case (n)
            1:       r = RCP_2;
            2:       r = RCP_12;
            3:       r = RCP_30;
            4:       r = RCP_56;
            5:       r = RCP_90;
            6:       r = RCP_132;
            7:       r = RCP_182;
            8:       r = RCP_240;
            9:       r = RCP_306;
            10:      r = RCP_380;
            11:      r = RCP_462;
            default: r = RCP_552;
        endcase
        return r;
    endfunction

    // cosine of a Q30 angle in radians, Taylor series, rounded to Q0.15
    // term numerators stay below 2^34, so the rounded-up reciprocal gives the exact floor
    function automatic logic [COS_W-1:0] cos_from_x(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned p;
        logic [127:0]    prod;
        longint          sum;
        longint          v;
        x2   = (x * x) >> 30;
        term = longint'(ONE_Q30);
        sum  = ONE_Q30;
        for (int n = 1; n <= 12; n++)
        begin
            p    = (term * x2) >> 30;
            prod = 128'(p) * 128'(series_rcp(n));
            term = prod[127:64];
            if ((n % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        v = (sum + 64'sd16384) >>> 15;
        if (v > 64'sd32767)
            v = 64'sd32767;
        return v[COS_W-1:0];
    endfunction

endpackage

@@ rtl/lttc_cos_rom.sv @@
module lttc_cos_rom #(
    parameter int COS_TABLE_ENTRIES = lttc_pkg::COS_ENTRIES_DEF
) (
    input  logic                                     clk,
    input  logic [$clog2(COS_TABLE_ENTRIES+1)-1:0]   addr,
    output logic [lttc_pkg::COS_W-1:0]               data
);
    import lttc_pkg::*;

    logic [COS_W-1:0] rom [0:COS_TABLE_ENTRIES];
    logic [COS_W-1:0] data_reg;

    // quarter wave, entry k at angle pi/2 * k / entries
    for (genvar k = 0; k <= COS_TABLE_ENTRIES; k++)
    begin : g_rom
        localparam longint unsigned XK = (HALF_PI_Q30 * k) / COS_TABLE_ENTRIES;
        assign rom[k] = cos_from_x(XK);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

@@ rtl/lttc_ttc_div.sv @@
module lttc_ttc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lttc_pkg::div_ctrl_t           ctrl,
    input  logic [lttc_pkg::NUM_W-1:0]    num,
    input  logic [lttc_pkg::DEN_W-1:0]    den,
    output lttc_pkg::div_stat_t           stat,
    output logic [lttc_pkg::TTC_W-1:0]    quot
);
    import lttc_pkg::*;

    localparam int REM_W = DEN_W + 1;
    localparam int CNT_W = $clog2(TTC_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0] rem_reg;
    logic [TTC_W-1:0] low_reg;
    logic [DEN_W-1:0] den_reg;
    logic [TTC_W-1:0] q_reg;

    logic [REM_W-1:0] trial;
    logic [REM_W:0]   diff;
    logic             ge;

    // shared compare-subtract: first pass is the saturation check
    assign trial = (cnt_reg == '0) ? rem_reg : {rem_reg[DEN_W-1:0], low_reg[TTC_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign ge    = ~diff[REM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if ((cnt_reg == '0 && ge) || cnt_reg == CNT_W'(TTC_W))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= REM_W'(num[NUM_W-1:TTC_W]);
            low_reg <= num[TTC_W-1:0];
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                if (ge)
                    q_reg <= TTC_MAX;
            end
            else
            begin
                rem_reg <= ge ? diff[REM_W-1:0] : trial;
                low_reg <= {low_reg[TTC_W-2:0], 1'b0};
                q_reg   <= {q_reg[TTC_W-2:0], ge};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a preceding busy cycle");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= CNT_W'(TTC_W))
        else $error("divider step count out of range");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

@@ rtl/lidar_ttc_emergency_brake_top.sv @@
// channel  direction  transfer when          payload
// in       input      in_valid & in_ready    beam_range_mm, vehicle_speed, last_beam
// out      output     out_valid & out_ready  brake, min_ttc_ms, moving_forward
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// a used beam passes through transfer, angle, table index, cosine read, speed multiply,
// the divider (saturation check, then a shared compare-subtract pass per quotient bit), step
// a saturating quotient stops after the first pass; a beam facing away skips the divider
// a beam that is skipped (no return, not moving forward) goes from angle straight to step
// a last beam then enters emit to load the result, held there while out_valid is high and out_ready low
// in_ready is high only between beams; reset clears the scan state and sets the config registers to defaults
module lidar_ttc_emergency_brake_top #(
    parameter int MAX_BEAMS         = lttc_pkg::MAX_BEAMS_DEF,
    parameter int COS_TABLE_ENTRIES = lttc_pkg::COS_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lttc_pkg::RANGE_W-1:0]       beam_range_mm,
    input  logic signed [lttc_pkg::SPEED_W-1:0] vehicle_speed,
    input  logic                               last_beam,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               brake,
    output logic [lttc_pkg::TTC_W-1:0]         min_ttc_ms,
    output logic                               moving_forward,
    input  logic                               cfg_we,
    input  logic [lttc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lttc_pkg::CFG_W-1:0]         cfg_data
);
    import lttc_pkg::*;

    localparam int BI_W  = $clog2(MAX_BEAMS);
    localparam int IDX_W = $clog2(COS_TABLE_ENTRIES + 1);
    localparam logic [BI_W-1:0] BI_LAST = BI_W'(MAX_BEAMS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ANGLE = 3'd1;
    localparam logic [2:0] S_INDEX = 3'd2;
    localparam logic [2:0] S_COS   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_STEP  = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;

    logic [TTC_W-1:0]   threshold_reg;
    logic [ANGLE_W-1:0] start_reg;
    logic [STEP_W-1:0]  step_reg;

    logic [BI_W-1:0]    beam_index_reg;
    logic [TTC_W-1:0]   min_ttc_reg;
    logic [SPEED_W-1:0] speed_reg;

    logic               out_valid_reg;
    logic               brake_reg;
    logic [TTC_W-1:0]   out_ttc_reg;
    logic               fwd_out_reg;

    logic [RANGE_W-1:0] range_reg;
    logic               last_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [IDX_W-1:0]   tab_idx_reg;
    logic               neg_reg;

    logic               fwd;
    logic               in_xfer;
    logic               out_free;
    logic               cos_use;
    logic [31:0]        step_prod;
    logic [31:0]        idx_prod;
    logic [IDX_W-1:0]   idx_i;
    logic [COS_W-1:0]   cos_val;
    logic [DEN_W-1:0]   closing;
    logic [NUM_W-1:0]   num;
    logic [25:0]        range_ms;

    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;
    logic [TTC_W-1:0]   div_quot;

    assign fwd      = ~speed_reg[SPEED_W-1] && (speed_reg != '0);
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = ~out_valid_reg || out_ready;

    assign step_prod = 32'(beam_index_reg) * 32'(step_reg);
    assign idx_prod  = 32'(angle_reg[ANGLE_W-3:0]) * 32'(COS_TABLE_ENTRIES);
    assign idx_i     = IDX_W'(idx_prod >> (ANGLE_W - 2));

    assign cos_use  = ~neg_reg && (cos_val != '0);
    assign closing  = DEN_W'(speed_reg[SPEED_W-2:0] * cos_val);
    assign range_ms = 26'(range_reg) * 26'(MS_PER_S);
    assign num      = {range_ms, 15'b0};

    assign div_ctrl.start = (state_reg == S_MUL) && cos_use;

    lttc_cos_rom #(
        .COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)
    ) u_cos_rom (
        .clk  (clk),
        .addr (tab_idx_reg),
        .data (cos_val)
    );

    lttc_ttc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (num),
        .den   (closing),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_xfer) state_next = S_ANGLE;
            S_ANGLE: state_next = (fwd && range_reg != NO_RETURN) ? S_INDEX : S_STEP;
            S_INDEX: state_next = S_COS;
            S_COS:   state_next = S_MUL;
            S_MUL:   state_next = cos_use ? S_DIV : S_STEP;
            S_DIV:   if (div_stat.done) state_next = S_STEP;
            S_STEP:  state_next = last_reg ? S_EMIT : S_IDLE;
            S_EMIT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            threshold_reg  <= THRESHOLD_RST;
            start_reg      <= START_RST;
            step_reg       <= STEP_RST;
            beam_index_reg <= '0;
            min_ttc_reg    <= TTC_MAX;
            speed_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: threshold_reg <= cfg_data;
                    CFG_START:     start_reg     <= cfg_data;
                    CFG_STEP:      step_reg      <= cfg_data[STEP_W-1:0];
                    default:       ;
                endcase
            end

            // speed is taken on the first beam of a scan only
            if (in_xfer && beam_index_reg == '0)
                speed_reg <= vehicle_speed;

            if (state_reg == S_DIV && div_stat.done && div_quot < min_ttc_reg)
                min_ttc_reg <= div_quot;

            if (state_reg == S_STEP && beam_index_reg != BI_LAST)
                beam_index_reg <= beam_index_reg + 1'b1;

            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg  <= 1'b1;
                beam_index_reg <= '0;
                min_ttc_reg    <= TTC_MAX;
                speed_reg      <= '0;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            range_reg <= beam_range_mm;
            last_reg  <= last_beam;
        end
        if (state_reg == S_ANGLE)
            angle_reg <= start_reg + step_prod[ANGLE_W-1:0];
        if (state_reg == S_INDEX)
        begin
            // quadrants 1 and 3 mirror the table, 1 and 2 negate it
            unique case (angle_reg[ANGLE_W-1:ANGLE_W-2])
                2'd0:    tab_idx_reg <= idx_i;
                2'd1:    tab_idx_reg <= IDX_W'(COS_TABLE_ENTRIES) - idx_i;
                2'd2:    tab_idx_reg <= idx_i;
                default: tab_idx_reg <= IDX_W'(COS_TABLE_ENTRIES) - idx_i;
            endcase
            neg_reg <= angle_reg[ANGLE_W-1] ^ angle_reg[ANGLE_W-2];
        end
        if (state_reg == S_EMIT && out_free)
        begin
            brake_reg   <= fwd && (min_ttc_reg < threshold_reg);
            out_ttc_reg <= min_ttc_reg;
            fwd_out_reg <= fwd;
        end
    end

    assign out_valid      = out_valid_reg;
    assign brake          = brake_reg;
    assign min_ttc_ms     = out_ttc_reg;
    assign moving_forward = fwd_out_reg;

    a_brake_needs_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !brake_reg || fwd_out_reg)
        else $error("brake requested while not moving forward");

    a_idle_ttc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !fwd_out_reg) |-> out_ttc_reg == TTC_MAX)
        else $error("ttc evaluated while not moving forward");

    a_scan_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=>
            beam_index_reg == '0 && min_ttc_reg == TTC_MAX && out_valid_reg)
        else $error("scan state not cleared after result");

    a_div_only_used: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> fwd && range_reg != NO_RETURN)
        else $error("divider started on an unused beam");

endmodule
